// File: hw/rtl/shifting_fifo_queue_defines.svh
// Assertion macros for the shifting FIFO queue.
// Used by the top level; no dependencies.
`ifndef SHIFTING_FIFO_QUEUE_DEFINES_SVH
`define SHIFTING_FIFO_QUEUE_DEFINES_SVH

`ifndef SYNTH
// cond must hold at every edge out of reset
`define SFQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// cons must hold at the same edge as ante
`define SFQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// cons must hold in the cycle after ante
`define SFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFQ_ASSERT_ALWAYS(lbl, cond, msg)
`define SFQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SFQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/sfq_pkg.sv
// Types and constants shared by the shifting FIFO queue modules.
// No dependencies.
package sfq_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int ITEM_W  = 31;
  localparam int DBL_W   = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_LIST  = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NEG   = 2'd3
  } status_e;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_DUMP = 1'b1
  } bk_state_e;

  // decoded command as it waits between front and back
  typedef struct packed {
    cmd_e              cmd;
    logic              neg;
    logic [ITEM_W-1:0] value;
  } op_t;

  typedef struct packed {
    status_e           status;
    logic [ITEM_W-1:0] item;
    logic [DBL_W-1:0]  doubled;
    logic [POS_W-1:0]  position;
    logic              last;
  } res_t;

endpackage

// File: hw/rtl/sfq_if.sv
// Valid/ready channel interfaces for the shifting FIFO queue.
// Depends on sfq_pkg for field widths.
interface sfq_in_if import sfq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface sfq_out_if import sfq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ITEM_W-1:0] item;
  logic [DBL_W-1:0]  doubled;
  logic [POS_W-1:0]  position;
  logic              last;

  modport source (output valid, output status, output item, output doubled,
                  output position, output last, input ready);
  modport sink (input valid, input status, input item, input doubled,
                input position, input last, output ready);
endinterface

// File: hw/rtl/sfq_front.sv
// Front end: decodes input commands and holds them in a two-entry op queue.
// Depends on sfq_pkg and sfq_in_if.
module sfq_front import sfq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  sfq_in_if.sink   in_ch,
  output logic     op_valid,
  output op_t      op,
  input  logic     op_ready
);

  op_t        q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;
  op_t        dec;

  always_comb begin
    dec.cmd   = cmd_e'(in_ch.command);
    dec.neg   = in_ch.value[VALUE_W-1];
    dec.value = in_ch.value[ITEM_W-1:0];
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign op_valid    = (fill_r != 2'd0);
  assign pop         = op_valid && op_ready;
  assign op          = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/sfq_back.sv
// Back end: shift-register queue storage, command execution and result register.
// Depends on sfq_pkg and sfq_out_if.
module sfq_back import sfq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         op_valid,
  input  op_t                          op,
  output logic                         op_ready,
  sfq_out_if.source                    out_ch,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] ent_r   [DEPTH];
  logic [ITEM_W-1:0] ent_nxt [DEPTH];
  logic [ITEM_W-1:0] shl_w   [DEPTH];

  bk_state_e         state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              flush_r, flush_nxt;
  res_t              res_r, res_nxt;
  logic              res_vld_r;

  logic              adv;
  logic              load;
  logic              shift;
  logic              recirc;
  logic              wr;
  logic [ITEM_W-1:0] head;

  assign head = ent_r[0];
  assign adv  = !res_vld_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    flush_nxt = flush_r;
    res_nxt   = '0;
    res_nxt.status = ST_OK;
    res_nxt.last   = 1'b1;
    op_ready  = 1'b0;
    load      = 1'b0;
    shift     = 1'b0;
    recirc    = 1'b0;
    wr        = 1'b0;
    unique case (state_r)
      BK_RUN: begin
        if (op_valid && adv) begin
          op_ready = 1'b1;
          load     = 1'b1;
          unique case (op.cmd)
            CMD_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else if (op.neg) begin
                res_nxt.status = ST_NEG;
              end else begin
                wr        = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                res_nxt.item    = head;
                res_nxt.doubled = {head, 1'b0};
                shift           = 1'b1;
                count_nxt       = count_r - CNT_W'(1);
              end
            end
            CMD_FLUSH, CMD_LIST: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                // emit the head and rotate it to the tail
                res_nxt.item = head;
                res_nxt.last = (count_r == CNT_W'(1));
                shift        = 1'b1;
                recirc       = 1'b1;
                if (count_r == CNT_W'(1)) begin
                  if (op.cmd == CMD_FLUSH) begin
                    count_nxt = '0;
                  end
                end else begin
                  state_nxt = BK_DUMP;
                  rem_nxt   = count_r - CNT_W'(1);
                  pos_nxt   = POS_W'(1);
                  flush_nxt = (op.cmd == CMD_FLUSH);
                end
              end
            end
          endcase
        end
      end
      BK_DUMP: begin
        if (adv) begin
          load             = 1'b1;
          res_nxt.item     = head;
          res_nxt.position = pos_r;
          res_nxt.last     = (rem_r == CNT_W'(1));
          shift            = 1'b1;
          recirc           = 1'b1;
          pos_nxt          = pos_r + POS_W'(1);
          rem_nxt          = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = BK_RUN;
            if (flush_r) begin
              count_nxt = '0;
            end
          end
        end
      end
    endcase
  end

  // per-entry next value: shift toward the head, refill the tail, or append
  for (genvar i = 0; i < DEPTH; i++) begin : g_ent
    if (i < DEPTH - 1) begin : g_mid
      assign shl_w[i] = ent_r[i+1];
    end else begin : g_end
      assign shl_w[i] = ent_r[i];
    end

    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (shift) begin
        if (recirc && count_r == CNT_W'(i + 1)) begin
          ent_nxt[i] = head;
        end else begin
          ent_nxt[i] = shl_w[i];
        end
      end else if (wr && count_r == CNT_W'(i)) begin
        ent_nxt[i] = op.value;
      end
    end

    always_ff @(posedge clk) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
    rem_r   <= rem_nxt;
    pos_r   <= pos_nxt;
    flush_r <= flush_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_RUN;
      count_r   <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (load) begin
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = res_vld_r;
  assign out_ch.status   = res_r.status;
  assign out_ch.item     = res_r.item;
  assign out_ch.doubled  = res_r.doubled;
  assign out_ch.position = res_r.position;
  assign out_ch.last     = res_r.last;
  assign count           = count_r;

endmodule

// File: hw/rtl/shifting_fifo_queue.sv
// Shifting FIFO queue of up to DEPTH non-negative 31-bit values. Commands are
// enqueue, dequeue (returns the head and twice the head), flush (dumps every
// entry in order, then empties) and list (dumps every entry, keeps them). Each
// accepted command yields one transfer on the result channel, except a dump
// of N entries, which yields N transfers; the final one of each command has
// last set, and an empty queue answers dequeue, flush and list with a single
// empty status. Commands pass through a two-entry queue into the execution
// stage, and results leave through an output register, so enqueue and dequeue
// sustain one command per cycle while the result channel is ready. A dump
// occupies the execution stage until all of its entries have gone out: the
// storage is a shift register and every dumped entry is one rotation of it
// out of the head. No initialization pass is needed after reset.
`include "shifting_fifo_queue_defines.svh"
// Depends on sfq_pkg, sfq_if, sfq_front and sfq_back.
module shifting_fifo_queue import sfq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sfq_in_if.sink    in_ch,
  sfq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             op_valid;
  logic             op_ready;
  op_t              op;
  logic [CNT_W-1:0] count;

  sfq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready)
  );

  sfq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .op_ready (op_ready),
    .out_ch   (out_ch),
    .count    (count)
  );

  `SFQ_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count above DEPTH")
  `SFQ_ASSERT_IMPLY(a_pop_valid, op_ready, op_valid, "back popped an empty op queue")
  `SFQ_ASSERT_IMPLY(a_mid_dump_ok, out_ch.valid && !out_ch.last,
                    out_ch.status == ST_OK, "non-final result without ok status")
  `SFQ_ASSERT_NEXT(a_deq_shrinks,
                   op_valid && op_ready && op.cmd == CMD_DEQ && count != '0,
                   count == $past(count) - CNT_W'(1), "dequeue did not shrink queue")

endmodule
